[rtl/gnd_pkg.sv]
// ----------------------------------------------------------------------------
// gnd_pkg
// Shared constants, word types and the gradient angle table for the 2D
// gradient-noise pipeline.
// ----------------------------------------------------------------------------
package gnd_pkg;

   // Coordinate format: unsigned fixed point with FRAC_BITS fraction bits.
   localparam int COORD_W     = 24;
   localparam int FRAC_BITS   = 8;
   localparam int INT_W       = COORD_W - FRAC_BITS;
   localparam int NUM_CORNERS = 4;

   // Corner order is (x0,y0), (x0+1,y0), (x0,y0+1), (x0+1,y0+1).
   localparam logic [NUM_CORNERS-1:0] X_STEP = 4'b1010;
   localparam logic [NUM_CORNERS-1:0] Y_STEP = 4'b1100;

   // Lattice hash multipliers.
   localparam logic [31:0] HASH_MUL_A = 32'd3284157443;
   localparam logic [31:0] HASH_MUL_B = 32'd1911520717;
   localparam logic [31:0] HASH_MUL_C = 32'd2048419325;

   // Gradient angle table: full circle split into ANGLE_DEPTH steps, stored
   // as one quadrant and unfolded by symmetry.
   localparam int DEPTH_LOG2    = 10;
   localparam int ANGLE_DEPTH   = 1 << DEPTH_LOG2;
   localparam int QTR_LOG2      = DEPTH_LOG2 - 2;
   localparam int QUARTER_DEPTH = 1 << QTR_LOG2;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // Quadrant codes taken from the top two bits of the angle index.
   localparam logic [1:0] QUAD_FIRST  = 2'd0;
   localparam logic [1:0] QUAD_SECOND = 2'd1;
   localparam logic [1:0] QUAD_THIRD  = 2'd2;
   localparam logic [1:0] QUAD_FOURTH = 2'd3;

   // Datapath widths.
   localparam int TRIG_W      = 15;                       // Q14 magnitude, up to 1.0
   localparam int GRAD_W      = TRIG_W + 1;               // signed Q1.14
   localparam int OFS_W       = FRAC_BITS + 1;            // signed offset
   localparam int MUL_W       = OFS_W + GRAD_W;           // offset times gradient
   localparam int GRAD_SHIFT  = 16 - FRAC_BITS;           // lift dot to Q30
   localparam int DOT_W       = MUL_W + 1 + GRAD_SHIFT;   // Q30 dot product
   localparam int DIFF_W      = DOT_W + 1;
   localparam int BPROD_W     = DIFF_W + OFS_W;
   localparam int P_W         = DOT_W + 1;                // mapped noise, Q31
   localparam int SPAN_W      = 17;
   localparam int SCALE_W     = P_W + SPAN_W;
   localparam int SCALE_SHIFT = 31;
   localparam int T_W         = SCALE_W - SCALE_SHIFT + 1;
   localparam int VALUE_W     = 16;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = CSR_ADDR_W - 2;
   localparam logic [REG_IDX_W-1:0] REG_LOWER_BOUND = 1'b0;
   localparam logic [REG_IDX_W-1:0] REG_UPPER_BOUND = 1'b1;

   typedef struct packed {
      logic [FRAC_BITS-1:0] sx;
      logic [FRAC_BITS-1:0] sy;
   } frac_pair_type;

   typedef struct packed {
      logic [NUM_CORNERS-1:0][DEPTH_LOG2-1:0] angle;
      frac_pair_type                          frac;
   } hash_word_type;

   typedef struct packed {
      logic [NUM_CORNERS-1:0][DOT_W-1:0] dot;
      frac_pair_type                     frac;
   } dot_word_type;

   typedef logic [2*TRIG_W-1:0] trig_entry_type;
   typedef trig_entry_type [QUARTER_DEPTH-1:0] trig_rom_type;

   // Builds the first-quadrant table {cos, sin} in Q14. Each entry comes from
   // a Taylor series worked in Q2.30 with truncating steps, clamped at zero
   // and rounded half up.
   function automatic trig_rom_type build_trig_rom();
      trig_rom_type rom;
      logic [63:0]  rem;
      logic [63:0]  th;
      logic [63:0]  th2;
      logic [63:0]  term;
      logic [63:0]  sq_w;
      logic [63:0]  cq_w;
      longint       ssum;
      longint       csum;
      rom = '0;
      for (int j = 0; j < QUARTER_DEPTH; j++) begin
         rem  = 64'(j) * 64'd4;
         th   = rem * HALF_PI_Q30 / ANGLE_DEPTH;
         th2  = (th * th) >> 30;
         term = th;
         ssum = $signed(th);
         for (int n = 1; n <= 6; n++) begin
            term = ((term * th2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
               ssum = ssum - $signed(term);
            end else begin
               ssum = ssum + $signed(term);
            end
         end
         term = 64'd1 << 30;
         csum = $signed(term);
         for (int n = 1; n <= 6; n++) begin
            term = ((term * th2) >> 30) / 64'((2 * n - 1) * (2 * n));
            if (n % 2 == 1) begin
               csum = csum - $signed(term);
            end else begin
               csum = csum + $signed(term);
            end
         end
         if (ssum < 0) begin
            ssum = 0;
         end
         if (csum < 0) begin
            csum = 0;
         end
         sq_w   = 64'(ssum) + 64'd32768;
         cq_w   = 64'(csum) + 64'd32768;
         rom[j] = {cq_w[TRIG_W+15:16], sq_w[TRIG_W+15:16]};
      end
      return rom;
   endfunction

   localparam trig_rom_type TRIG_ROM = build_trig_rom();

endpackage

[rtl/gnd_hash.sv]
// ----------------------------------------------------------------------------
// gnd_hash
// Splits the sample position into lattice cell and fraction and runs the
// multiply, rotate and xor hash for all four corners in three stages, one
// 32-bit multiply per stage and corner. Emits the angle index per corner.
// ----------------------------------------------------------------------------
module gnd_hash (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_stall,
   input  logic [gnd_pkg::COORD_W-1:0] in_x_coord,
   input  logic [gnd_pkg::COORD_W-1:0] in_y_coord,
   output logic                         out_valid,
   input  logic                         out_stall,
   output gnd_pkg::hash_word_type       out_word
);

   localparam int STAGES = 3;

   function automatic logic [31:0] rotl16(input logic [31:0] v);
      return {v[15:0], v[31:16]};
   endfunction

   logic [STAGES-1:0] valid_ff;
   logic [STAGES:0]   load;

   // Stage 0: first multiply of the x corner.
   logic [31:0]                      s0_a_in  [gnd_pkg::NUM_CORNERS];
   logic [31:0]                      s0_a_ff  [gnd_pkg::NUM_CORNERS];
   logic [gnd_pkg::INT_W-1:0]        s0_y0_ff;
   gnd_pkg::frac_pair_type           s0_frac_ff;
   gnd_pkg::frac_pair_type           s0_frac_in;

   // Stage 1: mix in the y corner and multiply.
   logic [31:0]                      s1_a_ff  [gnd_pkg::NUM_CORNERS];
   logic [31:0]                      s1_b_in  [gnd_pkg::NUM_CORNERS];
   logic [31:0]                      s1_b_ff  [gnd_pkg::NUM_CORNERS];
   gnd_pkg::frac_pair_type           s1_frac_ff;

   // Stage 2: final mix and multiply, keep the top bits as angle index.
   logic [gnd_pkg::DEPTH_LOG2-1:0]   s2_k_in  [gnd_pkg::NUM_CORNERS];
   logic [gnd_pkg::DEPTH_LOG2-1:0]   s2_k_ff  [gnd_pkg::NUM_CORNERS];
   gnd_pkg::frac_pair_type           s2_frac_ff;

   // A stage takes a new word when it is empty or its contents move on.
   always_comb begin
      load[STAGES] = !out_stall;
      for (int i = STAGES - 1; i >= 0; i--) begin
         load[i] = !valid_ff[i] || load[i+1];
      end
   end

   assign in_stall  = !load[0];
   assign out_valid = valid_ff[STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (load[0]) valid_ff[0] <= in_valid;
         for (int i = 1; i < STAGES; i++) begin
            if (load[i]) valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   // Hash arithmetic for each corner.
   always_comb begin
      logic [31:0] ix;
      logic [31:0] iy;
      logic [31:0] h;
      s0_frac_in.sx = in_x_coord[gnd_pkg::FRAC_BITS-1:0];
      s0_frac_in.sy = in_y_coord[gnd_pkg::FRAC_BITS-1:0];
      for (int c = 0; c < gnd_pkg::NUM_CORNERS; c++) begin
         ix = 32'(in_x_coord[gnd_pkg::COORD_W-1:gnd_pkg::FRAC_BITS])
            + 32'(gnd_pkg::X_STEP[c]);
         s0_a_in[c] = ix * gnd_pkg::HASH_MUL_A;
         iy = 32'(s0_y0_ff) + 32'(gnd_pkg::Y_STEP[c]);
         s1_b_in[c] = (iy ^ rotl16(s0_a_ff[c])) * gnd_pkg::HASH_MUL_B;
         h = (s1_a_ff[c] ^ rotl16(s1_b_ff[c])) * gnd_pkg::HASH_MUL_C;
         s2_k_in[c] = h[31 -: gnd_pkg::DEPTH_LOG2];
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         s0_a_ff    <= s0_a_in;
         s0_y0_ff   <= in_y_coord[gnd_pkg::COORD_W-1:gnd_pkg::FRAC_BITS];
         s0_frac_ff <= s0_frac_in;
      end
      if (load[1]) begin
         s1_a_ff    <= s0_a_ff;
         s1_b_ff    <= s1_b_in;
         s1_frac_ff <= s0_frac_ff;
      end
      if (load[2]) begin
         s2_k_ff    <= s2_k_in;
         s2_frac_ff <= s1_frac_ff;
      end
   end

   always_comb begin
      out_word.frac = s2_frac_ff;
      for (int c = 0; c < gnd_pkg::NUM_CORNERS; c++) begin
         out_word.angle[c] = s2_k_ff[c];
      end
   end

endmodule

[rtl/gnd_grad.sv]
// ----------------------------------------------------------------------------
// gnd_grad
// Turns each corner's angle index into a unit gradient through the quadrant
// table and dots it with the offset from that corner to the sample. Three
// stages: table lookup, products, sum lifted to Q30.
// ----------------------------------------------------------------------------
module gnd_grad (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_stall,
   input  gnd_pkg::hash_word_type in_word,
   output logic                   out_valid,
   input  logic                   out_stall,
   output gnd_pkg::dot_word_type  out_word
);

   localparam int STAGES = 3;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES:0]   load;

   logic signed [gnd_pkg::GRAD_W-1:0] s0_gc_in [gnd_pkg::NUM_CORNERS];
   logic signed [gnd_pkg::GRAD_W-1:0] s0_gs_in [gnd_pkg::NUM_CORNERS];
   logic signed [gnd_pkg::GRAD_W-1:0] s0_gc_ff [gnd_pkg::NUM_CORNERS];
   logic signed [gnd_pkg::GRAD_W-1:0] s0_gs_ff [gnd_pkg::NUM_CORNERS];
   gnd_pkg::frac_pair_type            s0_frac_ff;

   logic signed [gnd_pkg::MUL_W-1:0]  s1_px_in [gnd_pkg::NUM_CORNERS];
   logic signed [gnd_pkg::MUL_W-1:0]  s1_py_in [gnd_pkg::NUM_CORNERS];
   logic signed [gnd_pkg::MUL_W-1:0]  s1_px_ff [gnd_pkg::NUM_CORNERS];
   logic signed [gnd_pkg::MUL_W-1:0]  s1_py_ff [gnd_pkg::NUM_CORNERS];
   gnd_pkg::frac_pair_type            s1_frac_ff;

   logic signed [gnd_pkg::DOT_W-1:0]  s2_n_in  [gnd_pkg::NUM_CORNERS];
   logic signed [gnd_pkg::DOT_W-1:0]  s2_n_ff  [gnd_pkg::NUM_CORNERS];
   gnd_pkg::frac_pair_type            s2_frac_ff;

   // A stage takes a new word when it is empty or its contents move on.
   always_comb begin
      load[STAGES] = !out_stall;
      for (int i = STAGES - 1; i >= 0; i--) begin
         load[i] = !valid_ff[i] || load[i+1];
      end
   end

   assign in_stall  = !load[0];
   assign out_valid = valid_ff[STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (load[0]) valid_ff[0] <= in_valid;
         for (int i = 1; i < STAGES; i++) begin
            if (load[i]) valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   // Gradient lookup: the quadrant folds the stored cos and sin into place.
   always_comb begin
      logic [gnd_pkg::DEPTH_LOG2-1:0]   k;
      gnd_pkg::trig_entry_type          entry;
      logic signed [gnd_pkg::GRAD_W-1:0] cpos;
      logic signed [gnd_pkg::GRAD_W-1:0] spos;
      for (int c = 0; c < gnd_pkg::NUM_CORNERS; c++) begin
         k     = in_word.angle[c];
         entry = gnd_pkg::TRIG_ROM[k[gnd_pkg::QTR_LOG2-1:0]];
         cpos  = $signed({1'b0, entry[2*gnd_pkg::TRIG_W-1:gnd_pkg::TRIG_W]});
         spos  = $signed({1'b0, entry[gnd_pkg::TRIG_W-1:0]});
         case (k[gnd_pkg::DEPTH_LOG2-1 -: 2])
            gnd_pkg::QUAD_FIRST: begin
               s0_gc_in[c] = cpos;
               s0_gs_in[c] = spos;
            end
            gnd_pkg::QUAD_SECOND: begin
               s0_gc_in[c] = -spos;
               s0_gs_in[c] = cpos;
            end
            gnd_pkg::QUAD_THIRD: begin
               s0_gc_in[c] = -cpos;
               s0_gs_in[c] = -spos;
            end
            gnd_pkg::QUAD_FOURTH: begin
               s0_gc_in[c] = spos;
               s0_gs_in[c] = -cpos;
            end
            default: begin
               s0_gc_in[c] = cpos;
               s0_gs_in[c] = spos;
            end
         endcase
      end
   end

   // Offsets: the fraction for the low corner, fraction minus one for the
   // high corner, which is the fraction with a set sign bit.
   always_comb begin
      logic signed [gnd_pkg::OFS_W-1:0] dx;
      logic signed [gnd_pkg::OFS_W-1:0] dy;
      for (int c = 0; c < gnd_pkg::NUM_CORNERS; c++) begin
         dx = $signed({gnd_pkg::X_STEP[c], s0_frac_ff.sx});
         dy = $signed({gnd_pkg::Y_STEP[c], s0_frac_ff.sy});
         s1_px_in[c] = dx * s0_gc_ff[c];
         s1_py_in[c] = dy * s0_gs_ff[c];
         s2_n_in[c]  = (gnd_pkg::DOT_W'(s1_px_ff[c]) + gnd_pkg::DOT_W'(s1_py_ff[c]))
                       <<< gnd_pkg::GRAD_SHIFT;
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         s0_gc_ff   <= s0_gc_in;
         s0_gs_ff   <= s0_gs_in;
         s0_frac_ff <= in_word.frac;
      end
      if (load[1]) begin
         s1_px_ff   <= s1_px_in;
         s1_py_ff   <= s1_py_in;
         s1_frac_ff <= s0_frac_ff;
      end
      if (load[2]) begin
         s2_n_ff    <= s2_n_in;
         s2_frac_ff <= s1_frac_ff;
      end
   end

   always_comb begin
      out_word.frac = s2_frac_ff;
      for (int c = 0; c < gnd_pkg::NUM_CORNERS; c++) begin
         out_word.dot[c] = s2_n_ff[c];
      end
   end

endmodule

[rtl/gnd_blend.sv]
// ----------------------------------------------------------------------------
// gnd_blend
// Linear blend of the four corner dots: along x for both rows, then along y
// between the rows, and the map v + 1/2 into Q31. Each blend takes three
// stages: difference, multiply by the weight, floor shift and add.
// ----------------------------------------------------------------------------
module gnd_blend (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_stall,
   input  gnd_pkg::dot_word_type             in_word,
   output logic                              out_valid,
   input  logic                              out_stall,
   output logic signed [gnd_pkg::P_W-1:0]    out_noise
);

   localparam int STAGES = 6;
   localparam logic signed [gnd_pkg::P_W-1:0] ONE_Q30 = gnd_pkg::P_W'(64'd1 << 30);

   logic [STAGES-1:0] valid_ff;
   logic [STAGES:0]   load;

   // Row differences.
   logic signed [gnd_pkg::DOT_W-1:0]   s0_n0_ff;
   logic signed [gnd_pkg::DOT_W-1:0]   s0_n2_ff;
   logic signed [gnd_pkg::DIFF_W-1:0]  s0_d0_in;
   logic signed [gnd_pkg::DIFF_W-1:0]  s0_d1_in;
   logic signed [gnd_pkg::DIFF_W-1:0]  s0_d0_ff;
   logic signed [gnd_pkg::DIFF_W-1:0]  s0_d1_ff;
   gnd_pkg::frac_pair_type             s0_frac_ff;

   // Row differences times the x weight.
   logic signed [gnd_pkg::DOT_W-1:0]   s1_n0_ff;
   logic signed [gnd_pkg::DOT_W-1:0]   s1_n2_ff;
   logic signed [gnd_pkg::BPROD_W-1:0] s1_m0_in;
   logic signed [gnd_pkg::BPROD_W-1:0] s1_m1_in;
   logic signed [gnd_pkg::BPROD_W-1:0] s1_m0_ff;
   logic signed [gnd_pkg::BPROD_W-1:0] s1_m1_ff;
   logic [gnd_pkg::FRAC_BITS-1:0]      s1_sy_ff;

   // Row results.
   logic signed [gnd_pkg::DOT_W-1:0]   s2_r0_in;
   logic signed [gnd_pkg::DOT_W-1:0]   s2_r1_in;
   logic signed [gnd_pkg::DOT_W-1:0]   s2_r0_ff;
   logic signed [gnd_pkg::DOT_W-1:0]   s2_r1_ff;
   logic [gnd_pkg::FRAC_BITS-1:0]      s2_sy_ff;

   // Column difference.
   logic signed [gnd_pkg::DOT_W-1:0]   s3_r0_ff;
   logic signed [gnd_pkg::DIFF_W-1:0]  s3_dr_in;
   logic signed [gnd_pkg::DIFF_W-1:0]  s3_dr_ff;
   logic [gnd_pkg::FRAC_BITS-1:0]      s3_sy_ff;

   // Column difference times the y weight.
   logic signed [gnd_pkg::DOT_W-1:0]   s4_r0_ff;
   logic signed [gnd_pkg::BPROD_W-1:0] s4_m_in;
   logic signed [gnd_pkg::BPROD_W-1:0] s4_m_ff;

   // Blended and mapped noise.
   logic signed [gnd_pkg::P_W-1:0]     s5_p_in;
   logic signed [gnd_pkg::P_W-1:0]     s5_p_ff;

   // A stage takes a new word when it is empty or its contents move on.
   always_comb begin
      load[STAGES] = !out_stall;
      for (int i = STAGES - 1; i >= 0; i--) begin
         load[i] = !valid_ff[i] || load[i+1];
      end
   end

   assign in_stall  = !load[0];
   assign out_valid = valid_ff[STAGES-1];
   assign out_noise = s5_p_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (load[0]) valid_ff[0] <= in_valid;
         for (int i = 1; i < STAGES; i++) begin
            if (load[i]) valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   // Blend arithmetic; an arithmetic right shift gives the floor.
   always_comb begin
      s0_d0_in = gnd_pkg::DIFF_W'($signed(in_word.dot[1]))
               - gnd_pkg::DIFF_W'($signed(in_word.dot[0]));
      s0_d1_in = gnd_pkg::DIFF_W'($signed(in_word.dot[3]))
               - gnd_pkg::DIFF_W'($signed(in_word.dot[2]));
      s1_m0_in = s0_d0_ff * $signed({1'b0, s0_frac_ff.sx});
      s1_m1_in = s0_d1_ff * $signed({1'b0, s0_frac_ff.sx});
      s2_r0_in = s1_n0_ff + gnd_pkg::DOT_W'(s1_m0_ff >>> gnd_pkg::FRAC_BITS);
      s2_r1_in = s1_n2_ff + gnd_pkg::DOT_W'(s1_m1_ff >>> gnd_pkg::FRAC_BITS);
      s3_dr_in = gnd_pkg::DIFF_W'(s2_r1_ff) - gnd_pkg::DIFF_W'(s2_r0_ff);
      s4_m_in  = s3_dr_ff * $signed({1'b0, s3_sy_ff});
      s5_p_in  = gnd_pkg::P_W'(s4_r0_ff)
               + gnd_pkg::P_W'(s4_m_ff >>> gnd_pkg::FRAC_BITS) + ONE_Q30;
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         s0_n0_ff   <= $signed(in_word.dot[0]);
         s0_n2_ff   <= $signed(in_word.dot[2]);
         s0_d0_ff   <= s0_d0_in;
         s0_d1_ff   <= s0_d1_in;
         s0_frac_ff <= in_word.frac;
      end
      if (load[1]) begin
         s1_n0_ff <= s0_n0_ff;
         s1_n2_ff <= s0_n2_ff;
         s1_m0_ff <= s1_m0_in;
         s1_m1_ff <= s1_m1_in;
         s1_sy_ff <= s0_frac_ff.sy;
      end
      if (load[2]) begin
         s2_r0_ff <= s2_r0_in;
         s2_r1_ff <= s2_r1_in;
         s2_sy_ff <= s1_sy_ff;
      end
      if (load[3]) begin
         s3_r0_ff <= s2_r0_ff;
         s3_dr_ff <= s3_dr_in;
         s3_sy_ff <= s2_sy_ff;
      end
      if (load[4]) begin
         s4_r0_ff <= s3_r0_ff;
         s4_m_ff  <= s4_m_in;
      end
      if (load[5]) begin
         s5_p_ff <= s5_p_in;
      end
   end

endmodule

[rtl/gnd_scale.sv]
// ----------------------------------------------------------------------------
// gnd_scale
// Scales the Q31 noise onto the configured bounds and clamps it: first to the
// lower bound, then to the upper bound. The last stage is the result register
// seen on the output channel.
// ----------------------------------------------------------------------------
module gnd_scale (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [gnd_pkg::VALUE_W-1:0]       lower_bound,
   input  logic [gnd_pkg::VALUE_W-1:0]       upper_bound,
   input  logic                              in_valid,
   output logic                              in_stall,
   input  logic signed [gnd_pkg::P_W-1:0]    in_noise,
   output logic                              out_valid,
   input  logic                              out_stall,
   output logic [gnd_pkg::VALUE_W-1:0]       out_value
);

   localparam int STAGES = 2;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES:0]   load;

   logic signed [gnd_pkg::SPAN_W-1:0]  span;
   logic signed [gnd_pkg::SCALE_W-1:0] s0_prod_in;
   logic signed [gnd_pkg::SCALE_W-1:0] s0_prod_ff;
   logic signed [gnd_pkg::T_W-1:0]     lo_t;
   logic signed [gnd_pkg::T_W-1:0]     hi_t;
   logic signed [gnd_pkg::T_W-1:0]     scaled;
   logic signed [gnd_pkg::T_W-1:0]     floor_clamped;
   logic signed [gnd_pkg::T_W-1:0]     clamped;
   logic [gnd_pkg::VALUE_W-1:0]        s1_value_ff;

   // A stage takes a new word when it is empty or its contents move on.
   always_comb begin
      load[STAGES] = !out_stall;
      for (int i = STAGES - 1; i >= 0; i--) begin
         load[i] = !valid_ff[i] || load[i+1];
      end
   end

   assign in_stall  = !load[0];
   assign out_valid = valid_ff[STAGES-1];
   assign out_value = s1_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (load[0]) valid_ff[0] <= in_valid;
         for (int i = 1; i < STAGES; i++) begin
            if (load[i]) valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   // Multiply by the span, then shift down, offset and clamp.
   always_comb begin
      span       = $signed(gnd_pkg::SPAN_W'(upper_bound))
                 - $signed(gnd_pkg::SPAN_W'(lower_bound));
      s0_prod_in = in_noise * span;
      lo_t       = $signed(gnd_pkg::T_W'(lower_bound));
      hi_t       = $signed(gnd_pkg::T_W'(upper_bound));
      scaled     = gnd_pkg::T_W'(s0_prod_ff >>> gnd_pkg::SCALE_SHIFT) + lo_t;
      floor_clamped = (scaled < lo_t) ? lo_t : scaled;
      clamped       = (floor_clamped > hi_t) ? hi_t : floor_clamped;
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         s0_prod_ff <= s0_prod_in;
      end
      if (load[1]) begin
         s1_value_ff <= clamped[gnd_pkg::VALUE_W-1:0];
      end
   end

endmodule

[rtl/gradient_noise_2d.sv]
// Throughput: one word per cycle while rsp_stall is low. The hash
// multipliers and the gradient table are replicated per corner, and they
// and the blend multipliers each have a stage of their own.
// Stalls are absorbed stage by stage, so empty stages still fill up.
// Reset clears all valid bits; lower_bound resets to 0, upper_bound to 65535.
// ----------------------------------------------------------------------------
// gradient_noise_2d
// 2D gradient noise on a hashed integer lattice with linear blending, scaled
// and clamped to two programmable bounds.
// ----------------------------------------------------------------------------
module gradient_noise_2d (
   input  logic                            clock,
   input  logic                            reset,
   // Request channel.
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [gnd_pkg::COORD_W-1:0]    req_x_coord,
   input  logic [gnd_pkg::COORD_W-1:0]    req_y_coord,
   // Response channel.
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [gnd_pkg::VALUE_W-1:0]    rsp_noise_value,
   // Register port.
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [gnd_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [gnd_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [gnd_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);

   logic [gnd_pkg::VALUE_W-1:0]     lower_ff;
   logic [gnd_pkg::VALUE_W-1:0]     upper_ff;
   logic [gnd_pkg::REG_IDX_W-1:0]   reg_idx;

   logic                            hash_valid;
   logic                            hash_stall;
   gnd_pkg::hash_word_type          hash_word;
   logic                            dot_valid;
   logic                            dot_stall;
   gnd_pkg::dot_word_type           dot_word;
   logic                            noise_valid;
   logic                            noise_stall;
   logic signed [gnd_pkg::P_W-1:0]  noise;

   // Register file: writes complete in the access phase, no wait states.
   assign pready  = 1'b1;
   assign reg_idx = paddr[gnd_pkg::CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff <= '0;
         upper_ff <= '1;
      end else if (psel && penable && pwrite && pready) begin
         case (reg_idx)
            gnd_pkg::REG_LOWER_BOUND: lower_ff <= pwdata[gnd_pkg::VALUE_W-1:0];
            gnd_pkg::REG_UPPER_BOUND: upper_ff <= pwdata[gnd_pkg::VALUE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         gnd_pkg::REG_LOWER_BOUND: prdata = gnd_pkg::CSR_DATA_W'(lower_ff);
         gnd_pkg::REG_UPPER_BOUND: prdata = gnd_pkg::CSR_DATA_W'(upper_ff);
         default:                  prdata = '0;
      endcase
   end

   // Corner hashing.
   gnd_hash u_hash (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_stall   (req_stall),
      .in_x_coord (req_x_coord),
      .in_y_coord (req_y_coord),
      .out_valid  (hash_valid),
      .out_stall  (hash_stall),
      .out_word   (hash_word)
   );

   // Gradients and corner dot products.
   gnd_grad u_grad (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (hash_valid),
      .in_stall  (hash_stall),
      .in_word   (hash_word),
      .out_valid (dot_valid),
      .out_stall (dot_stall),
      .out_word  (dot_word)
   );

   // Bilinear blend and map to Q31.
   gnd_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dot_valid),
      .in_stall  (dot_stall),
      .in_word   (dot_word),
      .out_valid (noise_valid),
      .out_stall (noise_stall),
      .out_noise (noise)
   );

   // Scale, clamp and output register.
   gnd_scale u_scale (
      .clock       (clock),
      .reset       (reset),
      .lower_bound (lower_ff),
      .upper_bound (upper_ff),
      .in_valid    (noise_valid),
      .in_stall    (noise_stall),
      .in_noise    (noise),
      .out_valid   (rsp_valid),
      .out_stall   (rsp_stall),
      .out_value   (rsp_noise_value)
   );

endmodule

[tb/sv/gnd_noise_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnd_noise_checker
// Watches the request, response and register ports of gradient_noise_2d.
// Every accepted request word is turned into an expected noise value by an
// independent fixed-point model, and every response word is compared with
// the oldest expected value. Register reads are checked against a local copy.
// ----------------------------------------------------------------------------
module gnd_noise_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [gnd_pkg::COORD_W-1:0]    req_x_coord,
   input  logic [gnd_pkg::COORD_W-1:0]    req_y_coord,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [gnd_pkg::VALUE_W-1:0]    rsp_noise_value,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [gnd_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [gnd_pkg::CSR_DATA_W-1:0] pwdata,
   input  logic [gnd_pkg::CSR_DATA_W-1:0] prdata,
   input  logic                            pready,
   output int                              pending_count,
   output int                              fail_count
);
   import gnd_pkg::*;

   logic [VALUE_W-1:0] lower_copy;
   logic [VALUE_W-1:0] upper_copy;
   logic [VALUE_W-1:0] expected_noise_q[$];
   int                 mismatch_total = 0;

   assign fail_count = mismatch_total;

   // One line per mismatch, and every mismatch is counted.
   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      mismatch_total++;
   endtask

   // 32-bit lattice hash: multiply, swap halves, xor, with wrap-around.
   function automatic logic [31:0] lattice_hash(input logic [31:0] ix,
                                                input logic [31:0] iy);
      logic [31:0] a;
      logic [31:0] b;
      a = ix * HASH_MUL_A;
      b = iy ^ {a[15:0], a[31:16]};
      b = b * HASH_MUL_B;
      a = a ^ {b[15:0], b[31:16]};
      a = a * HASH_MUL_C;
      return a;
   endfunction

   // Unit gradient for one angle step, cos and sin in signed Q1.14. The
   // first-quadrant values come from truncated Taylor sums in Q2.30.
   function automatic void angle_gradient(input logic [DEPTH_LOG2-1:0] angle,
                                          output longint grad_c,
                                          output longint grad_s);
      logic [63:0] theta;
      logic [63:0] theta_sq;
      logic [63:0] term_s;
      logic [63:0] term_c;
      longint      sin_acc;
      longint      cos_acc;
      longint      sin_q;
      longint      cos_q;
      theta    = 64'(angle[QTR_LOG2-1:0]) * 64'd4 * HALF_PI_Q30 / 64'(ANGLE_DEPTH);
      theta_sq = (theta * theta) >> 30;
      term_s   = theta;
      term_c   = 64'd1 << 30;
      sin_acc  = longint'(theta);
      cos_acc  = longint'(term_c);
      for (int n = 1; n <= 6; n++) begin
         term_s = ((term_s * theta_sq) >> 30) / 64'((2 * n) * (2 * n + 1));
         term_c = ((term_c * theta_sq) >> 30) / 64'((2 * n - 1) * (2 * n));
         if (n % 2 == 1) begin
            sin_acc = sin_acc - longint'(term_s);
            cos_acc = cos_acc - longint'(term_c);
         end else begin
            sin_acc = sin_acc + longint'(term_s);
            cos_acc = cos_acc + longint'(term_c);
         end
      end
      if (sin_acc < 0) begin
         sin_acc = 0;
      end
      if (cos_acc < 0) begin
         cos_acc = 0;
      end
      sin_q = (sin_acc + 32768) >>> 16;
      cos_q = (cos_acc + 32768) >>> 16;
      // Unfold the quadrant from the top two angle bits.
      case (angle[DEPTH_LOG2-1 -: 2])
         QUAD_FIRST: begin
            grad_c = cos_q;
            grad_s = sin_q;
         end
         QUAD_SECOND: begin
            grad_c = -sin_q;
            grad_s = cos_q;
         end
         QUAD_THIRD: begin
            grad_c = -cos_q;
            grad_s = -sin_q;
         end
         default: begin
            grad_c = sin_q;
            grad_s = -cos_q;
         end
      endcase
   endfunction

   // Gradient of one corner dotted with the offset, lifted to Q30.
   function automatic longint corner_dot(input logic [31:0] ix, input logic [31:0] iy,
                                         input longint dx, input longint dy);
      logic [31:0] h;
      longint      gc;
      longint      gs;
      h = lattice_hash(ix, iy);
      angle_gradient(h[31 -: DEPTH_LOG2], gc, gs);
      return (dx * gc + dy * gs) * (longint'(1) << GRAD_SHIFT);
   endfunction

   // Linear blend with a floored fraction weight.
   function automatic longint lerp_floor(input longint a0, input longint a1,
                                         input longint w);
      return a0 + (((a1 - a0) * w) >>> FRAC_BITS);
   endfunction

   // Expected noise value for one coordinate pair and the current bounds.
   function automatic logic [VALUE_W-1:0] predict_noise(
      input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
      input logic [VALUE_W-1:0] lo_bound, input logic [VALUE_W-1:0] hi_bound);
      logic [31:0] ix;
      logic [31:0] iy;
      longint      sx;
      longint      sy;
      longint      one;
      longint      n00;
      longint      n10;
      longint      n01;
      longint      n11;
      longint      v;
      longint      p;
      longint      lo;
      longint      hi;
      longint      t;
      ix  = 32'(x[COORD_W-1:FRAC_BITS]);
      iy  = 32'(y[COORD_W-1:FRAC_BITS]);
      sx  = x[FRAC_BITS-1:0];
      sy  = y[FRAC_BITS-1:0];
      one = longint'(1) << FRAC_BITS;
      n00 = corner_dot(ix, iy, sx, sy);
      n10 = corner_dot(ix + 32'd1, iy, sx - one, sy);
      n01 = corner_dot(ix, iy + 32'd1, sx, sy - one);
      n11 = corner_dot(ix + 32'd1, iy + 32'd1, sx - one, sy - one);
      v   = lerp_floor(lerp_floor(n00, n10, sx), lerp_floor(n01, n11, sx), sy);
      // Map to [0,1] in Q31, scale into the bounds, then clamp max-then-min.
      p   = v + (longint'(1) << 30);
      lo  = lo_bound;
      hi  = hi_bound;
      t   = lo + ((p * (hi - lo)) >>> SCALE_SHIFT);
      if (t < lo) begin
         t = lo;
      end
      if (t > hi) begin
         t = hi;
      end
      return t[VALUE_W-1:0];
   endfunction

   // Monitor: register accesses, accepted request words, accepted responses.
   always @(posedge clock) begin
      logic [VALUE_W-1:0]    exp_value;
      logic [REG_IDX_W-1:0]  reg_idx;
      logic [CSR_DATA_W-1:0] reg_value;
      reg_idx = paddr[CSR_ADDR_W-1:2];
      if (reset) begin
         lower_copy = '0;
         upper_copy = '1;
         expected_noise_q.delete();
      end else begin
         if (psel && penable && pready) begin
            reg_value = (reg_idx == REG_LOWER_BOUND) ? CSR_DATA_W'(lower_copy)
                                                     : CSR_DATA_W'(upper_copy);
            if (pwrite) begin
               if (reg_idx == REG_LOWER_BOUND) begin
                  lower_copy = pwdata[VALUE_W-1:0];
               end else begin
                  upper_copy = pwdata[VALUE_W-1:0];
               end
            end else if (prdata !== reg_value) begin
               report_mismatch($sformatf("register %0d read %h, expected %h",
                                         reg_idx, prdata, reg_value));
            end
         end
         if (req_valid && !req_stall) begin
            expected_noise_q.insert(expected_noise_q.size(),
                                    predict_noise(req_x_coord, req_y_coord,
                                                  lower_copy, upper_copy));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_noise_q.size() == 0) begin
               report_mismatch($sformatf("response word %h with no request pending",
                                         rsp_noise_value));
            end else begin
               exp_value = expected_noise_q.pop_front();
               if (rsp_noise_value !== exp_value) begin
                  report_mismatch($sformatf("noise_value %h, expected %h",
                                            rsp_noise_value, exp_value));
               end
            end
         end
      end
      pending_count <= expected_noise_q.size();
   end

endmodule

[tb/sv/tb_gradient_noise_2d.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gradient_noise_2d
// Drives gradient_noise_2d with directed corner coordinates and then bursts
// of random coordinates under several bound settings, with random sender
// gaps and receiver stalls. Checking is done by gnd_noise_checker.
// ----------------------------------------------------------------------------
module tb_gradient_noise_2d;
   import gnd_pkg::*;

   localparam int IDLE_LIMIT      = 5000;
   localparam int PHASE_WORDS     = 50;
   localparam int NUM_SETTINGS    = 9;
   localparam int NUM_DIRECTED    = 14;
   localparam int SETTLE_CYCLES   = 20;

   localparam int STALL_NONE   = 0;
   localparam int STALL_LIGHT  = 1;
   localparam int STALL_HEAVY  = 2;
   localparam int STALL_TOGGLE = 3;
   localparam int STALL_BLOCK  = 4;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   logic [COORD_W-1:0]    req_x_coord = '0;
   logic [COORD_W-1:0]    req_y_coord = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   logic [VALUE_W-1:0]    rsp_noise_value;
   logic                  psel        = 1'b0;
   logic                  penable     = 1'b0;
   logic                  pwrite      = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr       = '0;
   logic [CSR_DATA_W-1:0] pwdata      = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   int                    pending_count;
   int                    fail_count;
   int                    idle_cycles = 0;
   int unsigned           stall_mode  = STALL_NONE;
   int unsigned           stall_run   = 0;

   // Lattice points, fraction extremes, coordinate extremes and bit patterns.
   logic [COORD_W-1:0] directed_x [NUM_DIRECTED] = '{
      24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000100, 24'h0000FF,
      24'h000080, 24'hFFFF00, 24'h0000FF, 24'h7FFF80, 24'h123456, 24'hAAAAAA,
      24'h555555, 24'hFFFFFF};
   logic [COORD_W-1:0] directed_y [NUM_DIRECTED] = '{
      24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'h000000, 24'h000100, 24'h0000FF,
      24'h000080, 24'h0000FF, 24'hFFFF00, 24'h800080, 24'hABCDEF, 24'h555555,
      24'hAAAAAA, 24'hFFFF01};

   // Bound settings per phase; the last two are drawn at random.
   logic [VALUE_W-1:0] setting_lower [NUM_SETTINGS] = '{
      16'd0, 16'd16384, 16'd65535, 16'd0, 16'd65535, 16'd30000, 16'd40000,
      16'd0, 16'd0};
   logic [VALUE_W-1:0] setting_upper [NUM_SETTINGS] = '{
      16'd65535, 16'd49152, 16'd0, 16'd0, 16'd65535, 16'd30001, 16'd20000,
      16'd0, 16'd0};

   gradient_noise_2d i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_x_coord     (req_x_coord),
      .req_y_coord     (req_y_coord),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_noise_value (rsp_noise_value),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   gnd_noise_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_x_coord     (req_x_coord),
      .req_y_coord     (req_y_coord),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_noise_value (rsp_noise_value),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready),
      .pending_count   (pending_count),
      .fail_count      (fail_count)
   );

   always #10 clock = ~clock;

   // Receiver stall pattern: runs of no stall, light, heavy, toggling or
   // solid stall, each of random length.
   always @(posedge clock) begin
      int unsigned next_mode;
      if (stall_run == 0) begin
         next_mode  = $urandom_range(STALL_NONE, STALL_BLOCK);
         stall_mode <= next_mode;
         stall_run  <= (next_mode == STALL_BLOCK) ? $urandom_range(1, 40)
                                                  : $urandom_range(8, 120);
         rsp_stall  <= 1'b0;
      end else begin
         stall_run <= stall_run - 1;
         case (stall_mode)
            STALL_NONE:   rsp_stall <= 1'b0;
            STALL_LIGHT:  rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:  rsp_stall <= ($urandom_range(0, 3) != 0);
            STALL_TOGGLE: rsp_stall <= ~rsp_stall;
            default:      rsp_stall <= 1'b1;
         endcase
      end
   end

   // Watchdog: ends the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Presents one coordinate word and holds it until it is taken.
   task automatic send_coord(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
      req_valid   <= 1'b1;
      req_x_coord <= x;
      req_y_coord <= y;
      do @(posedge clock); while (req_stall);
   endtask

   // Setup phase, then access phase held until pready, then an idle bus.
   task automatic csr_access(input logic is_write, input logic [REG_IDX_W-1:0] reg_idx,
                             input logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= {reg_idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Random coordinate: full range half of the time, with lattice points, fraction
   // extremes, the top integer row and small values mixed in.
   function automatic logic [COORD_W-1:0] pick_coord();
      logic [31:0] r;
      r = $urandom();
      case ($urandom_range(0, 7))
         0:       return {r[23:8], 8'h00};
         1:       return {r[23:8], 8'hFF};
         2:       return {16'hFFFF, r[7:0]};
         3:       return COORD_W'(r[11:0]);
         default: return r[23:0];
      endcase
   endfunction

   // Sends a number of words in bursts of random length with random gaps.
   task automatic send_bursts(input int total);
      int sent;
      int burst;
      int gap;
      sent = 0;
      while (sent < total) begin
         burst = $urandom_range(1, 16);
         for (int j = 0; j < burst && sent < total; j++) begin
            send_coord(pick_coord(), pick_coord());
            sent++;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Drops valid and waits until every expected word has come back.
   task automatic drain_words();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [VALUE_W-1:0] lo_val;
      logic [VALUE_W-1:0] hi_val;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words at the reset bounds, back to back.
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         send_coord(directed_x[i], directed_y[i]);
      end
      drain_words();

      // One phase per bound setting, both registers written and read back.
      for (int s = 0; s < NUM_SETTINGS; s++) begin
         lo_val = setting_lower[s];
         hi_val = setting_upper[s];
         if (s >= NUM_SETTINGS - 2) begin
            lo_val = VALUE_W'($urandom_range(0, 65535));
            hi_val = VALUE_W'($urandom_range(0, 65535));
         end
         csr_access(1'b1, REG_LOWER_BOUND, CSR_DATA_W'(lo_val));
         csr_access(1'b1, REG_UPPER_BOUND, CSR_DATA_W'(hi_val));
         csr_access(1'b0, REG_LOWER_BOUND, '0);
         csr_access(1'b0, REG_UPPER_BOUND, '0);
         send_bursts(PHASE_WORDS);
         drain_words();
      end

      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
